FILE: src/rmq_pkg.sv
// Shared constants and types for the rotation matrix to quaternion block.
package rmq_pkg;

    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 14;
    localparam int BR_W      = 2;
    localparam int LANES     = 4;

    // trace and radicand
    localparam int RAD_W = DATA_W + 2;
    localparam logic signed [RAD_W-1:0] ONE_Q = RAD_W'(2 ** FRAC_BITS);

    // off-diagonal sum or difference magnitude
    localparam int DM_W = DATA_W + 1;

    // first square root: radicand scaled by 2^FRAC_BITS
    localparam int SQ1_IN_W  = 32;
    localparam int SQ1_STEPS = SQ1_IN_W / 2;
    localparam int SQ1_ROOT_W = SQ1_STEPS;
    localparam int SQ1_REM_W = SQ1_ROOT_W + 2;

    // first divider: (mag << FRAC_BITS) + root over 2*root
    localparam int DV1_NUM_W  = 31;
    localparam int DV1_STEPS  = 23;
    localparam int DV1_DIV_W  = SQ1_ROOT_W + 1;
    localparam int QM_W       = DV1_STEPS;

    // norm
    localparam int SQR_W = 2 * QM_W;
    localparam int N2_W  = SQR_W + 2;
    localparam int SQ2_STEPS  = N2_W / 2;
    localparam int SQ2_ROOT_W = SQ2_STEPS;
    localparam int SQ2_REM_W  = SQ2_ROOT_W + 2;

    // second divider: (mag << FRAC_BITS) + nrm/2 over nrm, quotient at most 2^FRAC_BITS
    localparam int DV2_NUM_W = QM_W + FRAC_BITS + 1;
    localparam int DV2_STEPS = FRAC_BITS + 1;

    // branch codes
    localparam logic [BR_W-1:0] BR_TRACE = 2'd0;
    localparam logic [BR_W-1:0] BR_M00   = 2'd1;
    localparam logic [BR_W-1:0] BR_M11   = 2'd2;
    localparam logic [BR_W-1:0] BR_M22   = 2'd3;

    typedef struct packed {
        logic [BR_W-1:0]  branch;
        logic             bad;
        logic [LANES-1:0] neg;
    } ctl_t;

endpackage

FILE: src/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion (Shepperd), fully pipelined.
//
// Input channel: in_valid / in_stall with the nine Q1.14 matrix entries m00..m22.
// Output channel: out_valid / out_stall with qw, qx, qy, qz (Q1.14), the branch
// taken and bad_input. A beat moves when valid is high and stall is low.
//
// Throughput: one beat per cycle unless the output stalls. Path from input beat to
// output beat: entry stage, 16-stage radicand square root, 23-stage divider for the
// off-diagonal terms, quotient select, square, two adder stages, 24-stage norm
// square root, 15-stage normalising divider and the output register. Both roots
// and dividers retire one bit per stage.
//
// Reset clears every valid bit; the pipe then runs empty. When the receiver
// stalls a held result, the whole pipe freezes and in_stall is raised; while the
// output register is empty the pipe keeps advancing and taking beats.
// A radicand at or below zero gives a zero quaternion with bad_input set; the
// branch field still shows the branch chosen.
module rotation_matrix_to_quaternion (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [rmq_pkg::DATA_W-1:0]   m00,
    input  logic signed [rmq_pkg::DATA_W-1:0]   m01,
    input  logic signed [rmq_pkg::DATA_W-1:0]   m02,
    input  logic signed [rmq_pkg::DATA_W-1:0]   m10,
    input  logic signed [rmq_pkg::DATA_W-1:0]   m11,
    input  logic signed [rmq_pkg::DATA_W-1:0]   m12,
    input  logic signed [rmq_pkg::DATA_W-1:0]   m20,
    input  logic signed [rmq_pkg::DATA_W-1:0]   m21,
    input  logic signed [rmq_pkg::DATA_W-1:0]   m22,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [rmq_pkg::DATA_W-1:0]   qw,
    output logic signed [rmq_pkg::DATA_W-1:0]   qx,
    output logic signed [rmq_pkg::DATA_W-1:0]   qy,
    output logic signed [rmq_pkg::DATA_W-1:0]   qz,
    output logic [rmq_pkg::BR_W-1:0]            branch,
    output logic                                bad_input
);
    import rmq_pkg::*;

    logic adv;

    // ---------------------------------------------------------------- entry
    logic signed [RAD_W-1:0] tr;
    logic signed [RAD_W-1:0] rad;
    logic signed [DM_W-1:0]  dv [LANES];
    logic [BR_W-1:0]         br;

    logic                        a_valid_reg;
    ctl_t                        a_ctl_reg,  a_ctl_next;
    logic [SQ1_IN_W-1:0]         a_rad_reg,  a_rad_next;
    logic [LANES-1:0][DM_W-1:0]  a_mag_reg,  a_mag_next;

    // ---------------------------------------------------------------- root 1
    logic                              s1_valid_reg [SQ1_STEPS];
    ctl_t                              s1_ctl_reg   [SQ1_STEPS];
    logic [SQ1_REM_W-1:0]              s1_rem_reg   [SQ1_STEPS];
    logic [SQ1_REM_W-1:0]              s1_rem_next  [SQ1_STEPS];
    logic [SQ1_ROOT_W-1:0]             s1_root_reg  [SQ1_STEPS];
    logic [SQ1_ROOT_W-1:0]             s1_root_next [SQ1_STEPS];
    logic [SQ1_IN_W-1:0]               s1_num_reg   [SQ1_STEPS];
    logic [SQ1_IN_W-1:0]               s1_num_next  [SQ1_STEPS];
    logic [LANES-1:0][DM_W-1:0]        s1_mag_reg   [SQ1_STEPS];

    // ---------------------------------------------------------------- divider 1
    logic                              d1_valid_reg [DV1_STEPS];
    ctl_t                              d1_ctl_reg   [DV1_STEPS];
    logic [SQ1_ROOT_W-1:0]             d1_root_reg  [DV1_STEPS];
    logic [LANES-1:0][DV1_DIV_W-1:0]   d1_rem_reg   [DV1_STEPS];
    logic [LANES-1:0][DV1_DIV_W-1:0]   d1_rem_next  [DV1_STEPS];
    logic [LANES-1:0][QM_W-1:0]        d1_num_reg   [DV1_STEPS];
    logic [LANES-1:0][QM_W-1:0]        d1_num_next  [DV1_STEPS];

    // ---------------------------------------------------------------- norm
    logic                         q_valid_reg;
    ctl_t                         q_ctl_reg;
    logic [LANES-1:0][QM_W-1:0]   q_mag_reg, q_mag_next;

    logic                         sq_valid_reg;
    ctl_t                         sq_ctl_reg;
    logic [LANES-1:0][QM_W-1:0]   sq_mag_reg;
    logic [LANES-1:0][SQR_W-1:0]  sq_reg, sq_next;

    logic                         p_valid_reg;
    ctl_t                         p_ctl_reg;
    logic [LANES-1:0][QM_W-1:0]   p_mag_reg;
    logic [1:0][SQR_W:0]          p_reg;

    logic                         n2_valid_reg;
    ctl_t                         n2_ctl_reg;
    logic [LANES-1:0][QM_W-1:0]   n2_mag_reg;
    logic [N2_W-1:0]              n2_reg;

    // ---------------------------------------------------------------- root 2
    logic                         s2_valid_reg [SQ2_STEPS];
    ctl_t                         s2_ctl_reg   [SQ2_STEPS];
    logic [SQ2_REM_W-1:0]         s2_rem_reg   [SQ2_STEPS];
    logic [SQ2_REM_W-1:0]         s2_rem_next  [SQ2_STEPS];
    logic [SQ2_ROOT_W-1:0]        s2_root_reg  [SQ2_STEPS];
    logic [SQ2_ROOT_W-1:0]        s2_root_next [SQ2_STEPS];
    logic [N2_W-1:0]              s2_num_reg   [SQ2_STEPS];
    logic [N2_W-1:0]              s2_num_next  [SQ2_STEPS];
    logic [LANES-1:0][QM_W-1:0]   s2_mag_reg   [SQ2_STEPS];

    // ---------------------------------------------------------------- divider 2
    logic                               d2_valid_reg [DV2_STEPS];
    ctl_t                               d2_ctl_reg   [DV2_STEPS];
    logic [SQ2_ROOT_W-1:0]              d2_nrm_reg   [DV2_STEPS];
    logic [LANES-1:0][SQ2_ROOT_W-1:0]   d2_rem_reg   [DV2_STEPS];
    logic [LANES-1:0][SQ2_ROOT_W-1:0]   d2_rem_next  [DV2_STEPS];
    logic [LANES-1:0][DV2_STEPS-1:0]    d2_num_reg   [DV2_STEPS];
    logic [LANES-1:0][DV2_STEPS-1:0]    d2_num_next  [DV2_STEPS];

    // ---------------------------------------------------------------- output
    logic                                   out_valid_reg;
    logic [LANES-1:0][DATA_W-1:0]           out_q_reg, out_q_next;
    logic [BR_W-1:0]                        out_br_reg;
    logic                                   out_bad_reg;

    // The pipe moves as one; it holds only while a result sits stalled.
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // Branch choice and off-diagonal terms
    always_comb
    begin
        tr = RAD_W'(m00) + RAD_W'(m11) + RAD_W'(m22);
        for (int l = 0; l < LANES; l++)
        begin
            dv[l] = '0;
        end
        if (tr > 0)
        begin
            br    = BR_TRACE;
            rad   = tr + ONE_Q;
            dv[1] = DM_W'(m21) - DM_W'(m12);
            dv[2] = DM_W'(m02) - DM_W'(m20);
            dv[3] = DM_W'(m10) - DM_W'(m01);
        end
        else if (m00 > m11 && m00 > m22)
        begin
            br    = BR_M00;
            rad   = ONE_Q + RAD_W'(m00) - RAD_W'(m11) - RAD_W'(m22);
            dv[0] = DM_W'(m21) - DM_W'(m12);
            dv[2] = DM_W'(m01) + DM_W'(m10);
            dv[3] = DM_W'(m02) + DM_W'(m20);
        end
        else if (m11 > m22)
        begin
            br    = BR_M11;
            rad   = ONE_Q + RAD_W'(m11) - RAD_W'(m00) - RAD_W'(m22);
            dv[0] = DM_W'(m02) - DM_W'(m20);
            dv[1] = DM_W'(m01) + DM_W'(m10);
            dv[3] = DM_W'(m12) + DM_W'(m21);
        end
        else
        begin
            br    = BR_M22;
            rad   = ONE_Q + RAD_W'(m22) - RAD_W'(m00) - RAD_W'(m11);
            dv[0] = DM_W'(m10) - DM_W'(m01);
            dv[1] = DM_W'(m02) + DM_W'(m20);
            dv[2] = DM_W'(m12) + DM_W'(m21);
        end

        a_ctl_next.branch = br;
        a_ctl_next.bad    = (rad <= 0);
        // positive radicand is below 2^17, so the scaled value fits 31 bits
        a_rad_next = {1'b0, rad[DM_W-1:0], {FRAC_BITS{1'b0}}};
        for (int l = 0; l < LANES; l++)
        begin
            a_ctl_next.neg[l] = dv[l][DM_W-1];
            a_mag_next[l]     = dv[l][DM_W-1] ? DM_W'(-dv[l]) : DM_W'(dv[l]);
        end
    end

    // Radicand root, two radicand bits per stage
    always_comb
    begin
        logic [SQ1_REM_W-1:0]  src_rem;
        logic [SQ1_ROOT_W-1:0] src_root;
        logic [SQ1_IN_W-1:0]   src_num;
        logic [SQ1_REM_W-1:0]  rem_ext;
        logic [SQ1_REM_W-1:0]  trial;
        for (int k = 0; k < SQ1_STEPS; k++)
        begin
            src_rem  = (k == 0) ? '0        : s1_rem_reg[(k == 0) ? 0 : k - 1];
            src_root = (k == 0) ? '0        : s1_root_reg[(k == 0) ? 0 : k - 1];
            src_num  = (k == 0) ? a_rad_reg : s1_num_reg[(k == 0) ? 0 : k - 1];
            rem_ext  = {src_rem[SQ1_REM_W-3:0], src_num[SQ1_IN_W-1 -: 2]};
            trial    = {src_root, 2'b01};
            if (rem_ext >= trial)
            begin
                s1_rem_next[k]  = rem_ext - trial;
                s1_root_next[k] = {src_root[SQ1_ROOT_W-2:0], 1'b1};
            end
            else
            begin
                s1_rem_next[k]  = rem_ext;
                s1_root_next[k] = {src_root[SQ1_ROOT_W-2:0], 1'b0};
            end
            s1_num_next[k] = {src_num[SQ1_IN_W-3:0], 2'b00};
        end
    end

    // Off-diagonal division by s = 2*root, one quotient bit per stage.
    // s is at least 256 on good items, so the top eight bits preload the remainder.
    always_comb
    begin
        logic [SQ1_ROOT_W-1:0]  root;
        logic [DV1_DIV_W-1:0]   sdiv;
        logic [DV1_NUM_W-1:0]   numer;
        logic [DV1_DIV_W-1:0]   src_rem;
        logic [QM_W-1:0]        src_num;
        logic [DV1_DIV_W:0]     r;
        for (int k = 0; k < DV1_STEPS; k++)
        begin
            root = (k == 0) ? s1_root_reg[SQ1_STEPS-1] : d1_root_reg[(k == 0) ? 0 : k - 1];
            sdiv = {root, 1'b0};
            for (int l = 0; l < LANES; l++)
            begin
                numer = DV1_NUM_W'({s1_mag_reg[SQ1_STEPS-1][l], {FRAC_BITS{1'b0}}})
                      + DV1_NUM_W'(s1_root_reg[SQ1_STEPS-1]);
                if (k == 0)
                begin
                    src_rem = DV1_DIV_W'(numer[DV1_NUM_W-1:QM_W]);
                    src_num = numer[QM_W-1:0];
                end
                else
                begin
                    src_rem = d1_rem_reg[(k == 0) ? 0 : k - 1][l];
                    src_num = d1_num_reg[(k == 0) ? 0 : k - 1][l];
                end
                r = {src_rem, src_num[QM_W-1]};
                if (r >= {1'b0, sdiv})
                begin
                    d1_rem_next[k][l] = DV1_DIV_W'(r - {1'b0, sdiv});
                    d1_num_next[k][l] = {src_num[QM_W-2:0], 1'b1};
                end
                else
                begin
                    d1_rem_next[k][l] = r[DV1_DIV_W-1:0];
                    d1_num_next[k][l] = {src_num[QM_W-2:0], 1'b0};
                end
            end
        end
    end

    // Selected component is (root + 1) / 2, the rest are quotients
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (d1_ctl_reg[DV1_STEPS-1].branch == BR_W'(l))
            begin
                q_mag_next[l] = QM_W'(
                    (SQ1_ROOT_W'(d1_root_reg[DV1_STEPS-1]) + (SQ1_ROOT_W+1)'(1)) >> 1);
            end
            else
            begin
                q_mag_next[l] = d1_num_reg[DV1_STEPS-1][l];
            end
            sq_next[l] = SQR_W'(q_mag_reg[l]) * SQR_W'(q_mag_reg[l]);
        end
    end

    // Norm root
    always_comb
    begin
        logic [SQ2_REM_W-1:0]  src_rem;
        logic [SQ2_ROOT_W-1:0] src_root;
        logic [N2_W-1:0]       src_num;
        logic [SQ2_REM_W-1:0]  rem_ext;
        logic [SQ2_REM_W-1:0]  trial;
        for (int k = 0; k < SQ2_STEPS; k++)
        begin
            src_rem  = (k == 0) ? '0     : s2_rem_reg[(k == 0) ? 0 : k - 1];
            src_root = (k == 0) ? '0     : s2_root_reg[(k == 0) ? 0 : k - 1];
            src_num  = (k == 0) ? n2_reg : s2_num_reg[(k == 0) ? 0 : k - 1];
            rem_ext  = {src_rem[SQ2_REM_W-3:0], src_num[N2_W-1 -: 2]};
            trial    = {src_root, 2'b01};
            if (rem_ext >= trial)
            begin
                s2_rem_next[k]  = rem_ext - trial;
                s2_root_next[k] = {src_root[SQ2_ROOT_W-2:0], 1'b1};
            end
            else
            begin
                s2_rem_next[k]  = rem_ext;
                s2_root_next[k] = {src_root[SQ2_ROOT_W-2:0], 1'b0};
            end
            s2_num_next[k] = {src_num[N2_W-3:0], 2'b00};
        end
    end

    // Normalising division; every component is at most the norm, so the
    // quotient fits FRAC_BITS + 1 bits and the upper numerator preloads.
    always_comb
    begin
        logic [SQ2_ROOT_W-1:0]  nrm;
        logic [DV2_NUM_W-1:0]   numer;
        logic [SQ2_ROOT_W-1:0]  src_rem;
        logic [DV2_STEPS-1:0]   src_num;
        logic [SQ2_ROOT_W:0]    r;
        for (int k = 0; k < DV2_STEPS; k++)
        begin
            nrm = (k == 0) ? s2_root_reg[SQ2_STEPS-1] : d2_nrm_reg[(k == 0) ? 0 : k - 1];
            for (int l = 0; l < LANES; l++)
            begin
                numer = DV2_NUM_W'({s2_mag_reg[SQ2_STEPS-1][l], {FRAC_BITS{1'b0}}})
                      + DV2_NUM_W'(s2_root_reg[SQ2_STEPS-1] >> 1);
                if (k == 0)
                begin
                    src_rem = SQ2_ROOT_W'(numer[DV2_NUM_W-1:DV2_STEPS]);
                    src_num = numer[DV2_STEPS-1:0];
                end
                else
                begin
                    src_rem = d2_rem_reg[(k == 0) ? 0 : k - 1][l];
                    src_num = d2_num_reg[(k == 0) ? 0 : k - 1][l];
                end
                r = {src_rem, src_num[DV2_STEPS-1]};
                if (r >= {1'b0, nrm})
                begin
                    d2_rem_next[k][l] = SQ2_ROOT_W'(r - {1'b0, nrm});
                    d2_num_next[k][l] = {src_num[DV2_STEPS-2:0], 1'b1};
                end
                else
                begin
                    d2_rem_next[k][l] = r[SQ2_ROOT_W-1:0];
                    d2_num_next[k][l] = {src_num[DV2_STEPS-2:0], 1'b0};
                end
            end
        end
    end

    // Sign and bad-input zeroing
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (d2_ctl_reg[DV2_STEPS-1].bad)
            begin
                out_q_next[l] = '0;
            end
            else if (d2_ctl_reg[DV2_STEPS-1].neg[l])
            begin
                out_q_next[l] = -DATA_W'(d2_num_reg[DV2_STEPS-1][l]);
            end
            else
            begin
                out_q_next[l] = DATA_W'(d2_num_reg[DV2_STEPS-1][l]);
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            q_valid_reg   <= 1'b0;
            sq_valid_reg  <= 1'b0;
            p_valid_reg   <= 1'b0;
            n2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < SQ1_STEPS; k++)
            begin
                s1_valid_reg[k] <= 1'b0;
            end
            for (int k = 0; k < DV1_STEPS; k++)
            begin
                d1_valid_reg[k] <= 1'b0;
            end
            for (int k = 0; k < SQ2_STEPS; k++)
            begin
                s2_valid_reg[k] <= 1'b0;
            end
            for (int k = 0; k < DV2_STEPS; k++)
            begin
                d2_valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            for (int k = 0; k < SQ1_STEPS; k++)
            begin
                s1_valid_reg[k] <= (k == 0) ? a_valid_reg : s1_valid_reg[(k == 0) ? 0 : k - 1];
            end
            for (int k = 0; k < DV1_STEPS; k++)
            begin
                d1_valid_reg[k] <= (k == 0) ? s1_valid_reg[SQ1_STEPS-1]
                                            : d1_valid_reg[(k == 0) ? 0 : k - 1];
            end
            q_valid_reg  <= d1_valid_reg[DV1_STEPS-1];
            sq_valid_reg <= q_valid_reg;
            p_valid_reg  <= sq_valid_reg;
            n2_valid_reg <= p_valid_reg;
            for (int k = 0; k < SQ2_STEPS; k++)
            begin
                s2_valid_reg[k] <= (k == 0) ? n2_valid_reg : s2_valid_reg[(k == 0) ? 0 : k - 1];
            end
            for (int k = 0; k < DV2_STEPS; k++)
            begin
                d2_valid_reg[k] <= (k == 0) ? s2_valid_reg[SQ2_STEPS-1]
                                            : d2_valid_reg[(k == 0) ? 0 : k - 1];
            end
            out_valid_reg <= d2_valid_reg[DV2_STEPS-1];
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ctl_reg <= a_ctl_next;
            a_rad_reg <= a_rad_next;
            a_mag_reg <= a_mag_next;

            for (int k = 0; k < SQ1_STEPS; k++)
            begin
                s1_rem_reg[k]  <= s1_rem_next[k];
                s1_root_reg[k] <= s1_root_next[k];
                s1_num_reg[k]  <= s1_num_next[k];
                s1_ctl_reg[k]  <= (k == 0) ? a_ctl_reg : s1_ctl_reg[(k == 0) ? 0 : k - 1];
                s1_mag_reg[k]  <= (k == 0) ? a_mag_reg : s1_mag_reg[(k == 0) ? 0 : k - 1];
            end

            for (int k = 0; k < DV1_STEPS; k++)
            begin
                d1_rem_reg[k]  <= d1_rem_next[k];
                d1_num_reg[k]  <= d1_num_next[k];
                d1_root_reg[k] <= (k == 0) ? s1_root_reg[SQ1_STEPS-1]
                                           : d1_root_reg[(k == 0) ? 0 : k - 1];
                d1_ctl_reg[k]  <= (k == 0) ? s1_ctl_reg[SQ1_STEPS-1]
                                           : d1_ctl_reg[(k == 0) ? 0 : k - 1];
            end

            q_ctl_reg  <= d1_ctl_reg[DV1_STEPS-1];
            q_mag_reg  <= q_mag_next;

            sq_ctl_reg <= q_ctl_reg;
            sq_mag_reg <= q_mag_reg;
            sq_reg     <= sq_next;

            p_ctl_reg  <= sq_ctl_reg;
            p_mag_reg  <= sq_mag_reg;
            p_reg[0]   <= (SQR_W+1)'(sq_reg[0]) + (SQR_W+1)'(sq_reg[1]);
            p_reg[1]   <= (SQR_W+1)'(sq_reg[2]) + (SQR_W+1)'(sq_reg[3]);

            n2_ctl_reg <= p_ctl_reg;
            n2_mag_reg <= p_mag_reg;
            n2_reg     <= N2_W'(p_reg[0]) + N2_W'(p_reg[1]);

            for (int k = 0; k < SQ2_STEPS; k++)
            begin
                s2_rem_reg[k]  <= s2_rem_next[k];
                s2_root_reg[k] <= s2_root_next[k];
                s2_num_reg[k]  <= s2_num_next[k];
                s2_ctl_reg[k]  <= (k == 0) ? n2_ctl_reg : s2_ctl_reg[(k == 0) ? 0 : k - 1];
                s2_mag_reg[k]  <= (k == 0) ? n2_mag_reg : s2_mag_reg[(k == 0) ? 0 : k - 1];
            end

            for (int k = 0; k < DV2_STEPS; k++)
            begin
                d2_rem_reg[k] <= d2_rem_next[k];
                d2_num_reg[k] <= d2_num_next[k];
                d2_nrm_reg[k] <= (k == 0) ? s2_root_reg[SQ2_STEPS-1]
                                          : d2_nrm_reg[(k == 0) ? 0 : k - 1];
                d2_ctl_reg[k] <= (k == 0) ? s2_ctl_reg[SQ2_STEPS-1]
                                          : d2_ctl_reg[(k == 0) ? 0 : k - 1];
            end

            out_q_reg   <= out_q_next;
            out_br_reg  <= d2_ctl_reg[DV2_STEPS-1].branch;
            out_bad_reg <= d2_ctl_reg[DV2_STEPS-1].bad;
        end
    end

    assign out_valid = out_valid_reg;
    assign qw        = out_q_reg[0];
    assign qx        = out_q_reg[1];
    assign qy        = out_q_reg[2];
    assign qz        = out_q_reg[3];
    assign branch    = out_br_reg;
    assign bad_input = out_bad_reg;

endmodule
